// File: rtl/pfu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pfu_pkg
// Shared types, format codes and lookup tables of the PCM format unpacker.
// ============================================================================
package pfu_pkg;

    localparam int unsigned FmtW    = 5;
    localparam int unsigned ByteW   = 8;
    localparam int unsigned SampleW = 64;
    localparam int unsigned PosW    = 3;

    typedef logic [FmtW-1:0] t_fmt;

    // Input format codes
    localparam t_fmt FMT_U8      = 5'd0;
    localparam t_fmt FMT_S8      = 5'd1;
    localparam t_fmt FMT_S16LE   = 5'd2;
    localparam t_fmt FMT_S16BE   = 5'd3;
    localparam t_fmt FMT_U16LE   = 5'd4;
    localparam t_fmt FMT_U16BE   = 5'd5;
    localparam t_fmt FMT_S24LE   = 5'd6;
    localparam t_fmt FMT_S24BE   = 5'd7;
    localparam t_fmt FMT_U24LE   = 5'd8;
    localparam t_fmt FMT_U24BE   = 5'd9;
    localparam t_fmt FMT_S24LE32 = 5'd10;
    localparam t_fmt FMT_S24BE32 = 5'd11;
    localparam t_fmt FMT_S32LE   = 5'd12;
    localparam t_fmt FMT_S32BE   = 5'd13;
    localparam t_fmt FMT_U32LE   = 5'd14;
    localparam t_fmt FMT_U32BE   = 5'd15;
    localparam t_fmt FMT_S20BE   = 5'd16;
    localparam t_fmt FMT_F32LE   = 5'd17;
    localparam t_fmt FMT_F32BE   = 5'd18;
    localparam t_fmt FMT_F64LE   = 5'd19;
    localparam t_fmt FMT_F64BE   = 5'd20;
    localparam t_fmt FMT_DAT12   = 5'd21;
    localparam t_fmt FMT_COUNT   = 5'd22;

    // Decode result handed to the top level
    typedef struct packed {
        logic               emit;     // a sample completes with this byte
        logic               restart;  // group done: position and accumulator clear
        logic [SampleW-1:0] sample;
    } t_dec;

    // Bytes in one group of each format
    function automatic logic [3:0] group_len(input t_fmt fmt);
        logic [3:0] len;
        case (fmt)
            FMT_U8, FMT_S8:                                len = 4'd1;
            FMT_S16LE, FMT_S16BE, FMT_U16LE, FMT_U16BE:    len = 4'd2;
            FMT_S24LE, FMT_S24BE, FMT_U24LE, FMT_U24BE,
            FMT_DAT12:                                     len = 4'd3;
            FMT_S20BE:                                     len = 4'd5;
            FMT_F64LE, FMT_F64BE:                          len = 4'd8;
            default:                                       len = 4'd4;
        endcase
        return len;
    endfunction

    // DAT 12-bit nonlinear: segment offset
    function automatic logic [15:0] dat_off(input logic [3:0] seg);
        logic [15:0] off;
        case (seg)
            4'd0, 4'd1:   off = 16'h0000;
            4'd2:         off = 16'h0100;
            4'd3:         off = 16'h0200;
            4'd4:         off = 16'h0300;
            4'd5:         off = 16'h0400;
            4'd6:         off = 16'h0500;
            4'd7:         off = 16'h0600;
            4'd8:         off = 16'h0A00;
            4'd9:         off = 16'h0B00;
            4'd10:        off = 16'h0C00;
            4'd11:        off = 16'h0D00;
            4'd12:        off = 16'h0E00;
            4'd13:        off = 16'h0F00;
            default:      off = 16'h1000;
        endcase
        return off;
    endfunction

    // DAT 12-bit nonlinear: segment shift
    function automatic logic [2:0] dat_sh(input logic [3:0] seg);
        logic [2:0] sh;
        case (seg)
            4'd2, 4'd13:  sh = 3'd1;
            4'd3, 4'd12:  sh = 3'd2;
            4'd4, 4'd11:  sh = 3'd3;
            4'd5, 4'd10:  sh = 3'd4;
            4'd6, 4'd9:   sh = 3'd5;
            4'd7, 4'd8:   sh = 3'd6;
            default:      sh = 3'd0;
        endcase
        return sh;
    endfunction

endpackage

// File: rtl/pfu_decode.sv
`timescale 1ns / 1ps
// ============================================================================
// pfu_decode
// Turns the byte accumulator and group position into a finished sample.
// ============================================================================
module pfu_decode (
    input  pfu_pkg::t_fmt              i_mode,
    input  logic [pfu_pkg::SampleW-1:0] i_acc,  // already holds the new byte
    input  logic [pfu_pkg::PosW-1:0]    i_pos,  // bytes taken before this one
    output pfu_pkg::t_dec              o_dec
);
    import pfu_pkg::*;

    logic [3:0]  len;
    logic [3:0]  pos_inc;
    logic [31:0] g32;
    logic [31:0] sw32;
    logic [23:0] sw24;
    logic [63:0] sw64;
    logic [11:0] dat_code;
    logic [15:0] dat_diff;
    logic [15:0] dat_val;

    assign len     = group_len(i_mode);
    assign pos_inc = {1'b0, i_pos} + 4'd1;
    assign g32     = i_acc[31:0];
    assign sw24    = {i_acc[7:0], i_acc[15:8], i_acc[23:16]};
    assign sw32    = {i_acc[7:0], i_acc[15:8], i_acc[23:16], i_acc[31:24]};
    assign sw64    = {i_acc[7:0], i_acc[15:8], i_acc[23:16], i_acc[31:24],
                      i_acc[39:32], i_acc[47:40], i_acc[55:48], i_acc[63:56]};

    // DAT12: first sample sits in the top 12 of two bytes, second in the low 12
    assign dat_code = (i_pos == 3'd1) ? i_acc[15:4] : i_acc[11:0];
    assign dat_diff = {4'd0, dat_code} - dat_off(dat_code[11:8]);
    assign dat_val  = dat_diff << dat_sh(dat_code[11:8]);

    // Per-format sample decode; mid-scale subtraction is a top-bit flip
    always_comb begin
        o_dec = '0;
        case (i_mode)
            FMT_S20BE: begin
                if (i_pos == 3'd2) begin
                    o_dec.emit   = 1'b1;
                    o_dec.sample = {32'd0, i_acc[23:8], i_acc[7:4], 12'd0};
                end else if (i_pos >= 3'd4) begin
                    o_dec.emit    = 1'b1;
                    o_dec.restart = 1'b1;
                    o_dec.sample  = {32'd0, i_acc[19:0], 12'd0};
                end
            end
            FMT_DAT12: begin
                if (i_pos == 3'd1) begin
                    o_dec.emit   = 1'b1;
                    o_dec.sample = {48'd0, dat_val};
                end else if (i_pos >= 3'd2) begin
                    o_dec.emit    = 1'b1;
                    o_dec.restart = 1'b1;
                    o_dec.sample  = {48'd0, dat_val};
                end
            end
            default: begin
                if (pos_inc >= len) begin
                    o_dec.emit    = 1'b1;
                    o_dec.restart = 1'b1;
                end
                case (i_mode)
                    FMT_U8:      o_dec.sample = {56'd0, i_acc[7:0]};
                    FMT_S8:      o_dec.sample = {56'd0, ~i_acc[7], i_acc[6:0]};
                    FMT_S16LE:   o_dec.sample = {48'd0, i_acc[7:0], i_acc[15:8]};
                    FMT_S16BE:   o_dec.sample = {48'd0, i_acc[15:0]};
                    FMT_U16LE:   o_dec.sample = {48'd0, ~i_acc[7], i_acc[6:0], i_acc[15:8]};
                    FMT_U16BE:   o_dec.sample = {48'd0, ~i_acc[15], i_acc[14:0]};
                    FMT_S24LE:   o_dec.sample = {32'd0, sw24, 8'd0};
                    FMT_S24BE,
                    FMT_S24BE32: o_dec.sample = {32'd0, i_acc[23:0], 8'd0};
                    FMT_U24LE:   o_dec.sample = {32'd0, ~sw24[23], sw24[22:0], 8'd0};
                    FMT_U24BE:   o_dec.sample = {32'd0, ~i_acc[23], i_acc[22:0], 8'd0};
                    FMT_S24LE32: o_dec.sample = {32'd0, sw32[23:0], 8'd0};
                    FMT_S32LE:   o_dec.sample = {32'd0, sw32};
                    FMT_S32BE:   o_dec.sample = {32'd0, g32};
                    FMT_U32LE:   o_dec.sample = {32'd0, ~sw32[31], sw32[30:0]};
                    FMT_U32BE:   o_dec.sample = {32'd0, ~g32[31], g32[30:0]};
                    // Non-finite floats (exponent all ones) read as zero
                    FMT_F32LE:   o_dec.sample = (&sw32[30:23]) ? '0 : {32'd0, sw32};
                    FMT_F32BE:   o_dec.sample = (&g32[30:23]) ? '0 : {32'd0, g32};
                    FMT_F64LE:   o_dec.sample = (&sw64[62:52]) ? '0 : sw64;
                    FMT_F64BE:   o_dec.sample = (&i_acc[62:52]) ? '0 : i_acc;
                    default:     o_dec.sample = '0;
                endcase
            end
        endcase
    end

endmodule

// File: rtl/pcm_format_unpacker.sv
`timescale 1ns / 1ps
// ============================================================================
// pcm_format_unpacker
// Assembles a raw audio byte stream into native little-endian samples.
// ============================================================================
// One byte is taken per cycle, with no gap between bytes, as long as the
// output register is empty or is being drained in the same cycle; a sample
// appears on the master side in the cycle after the byte that completes it.
// The byte accumulator and group position hold the packing state; the whole
// decode sits between them and the output register. Write the format
// register only while the stream is idle; codes 22 to 31 drop bytes and
// produce nothing.
module pcm_format_unpacker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // format register write
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [pfu_pkg::FmtW-1:0]     i_cfg_data,     // [4:0] format_mode
    // byte stream in
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [pfu_pkg::ByteW-1:0]    s_axis_tdata,   // [7:0] data_byte
    input  logic                         s_axis_tlast,   // block_end
    // sample stream out
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [pfu_pkg::SampleW-1:0]  m_axis_tdata    // [63:0] sample
);
    import pfu_pkg::*;

    t_fmt               r_format;
    logic [SampleW-1:0] r_acc;
    logic [PosW-1:0]    r_pos;
    logic               r_out_valid;
    logic [SampleW-1:0] r_out_sample;

    logic [SampleW-1:0] n_acc;
    logic [SampleW-1:0] shifted_acc;
    logic [PosW-1:0]    n_pos;
    logic               accept;
    logic               fmt_known;
    t_dec               dec;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sample;

    assign accept      = s_axis_tvalid && s_axis_tready;
    assign fmt_known   = r_format < FMT_COUNT;
    assign shifted_acc = {r_acc[SampleW-ByteW-1:0], s_axis_tdata};

    pfu_decode u_decode (
        .i_mode   (r_format),
        .i_acc    (shifted_acc),
        .i_pos    (r_pos),
        .o_dec    (dec)
    );

    // Next accumulator and position
    always_comb begin
        if (!fmt_known || dec.restart || s_axis_tlast) begin
            n_acc = '0;
            n_pos = '0;
        end else begin
            n_acc = shifted_acc;
            n_pos = r_pos + 3'd1;
        end
    end

    // Format register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format <= FMT_U8;
        end else if (i_cfg_valid) begin
            r_format <= i_cfg_data;
        end
    end

    // Packing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_pos <= '0;
        end else if (accept) begin
            r_acc <= n_acc;
            r_pos <= n_pos;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_out_valid <= accept && fmt_known && dec.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && dec.emit) begin
            r_out_sample <= dec.sample;
        end
    end

endmodule
